// ===== src/cfp_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the frame parser.
package cfp_pkg;

	localparam int MAX_PAYLOAD_DEF = 256;

	localparam logic [7:0]  SOF_FIRST   = 8'hA5;
	localparam logic [7:0]  SOF_SECOND  = 8'h5A;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [2:0]  HEADER_LEN  = 3'd5;
	localparam logic [7:0]  VERSION_RST = 8'd1;

	typedef enum logic [2:0] {
		PH_HUNT1    = 3'd0,
		PH_HUNT2    = 3'd1,
		PH_HEADER   = 3'd2,
		PH_PAYLOAD  = 3'd3,
		PH_CHECK_LO = 3'd4,
		PH_CHECK_HI = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_OK     = 2'd1,
		EV_CRC    = 2'd2,
		EV_FORMAT = 2'd3
	} event_t;

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef struct packed {
		logic [7:0]  frame_kind;
		logic [7:0]  sequence_number;
		logic [8:0]  body_length;
		logic [31:0] valid_frame_count;
		logic [31:0] crc_error_count;
		logic [31:0] format_error_count;
	} stat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] v;
		v = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (v[15]) begin
				v = {v[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[14:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ===== src/cfp_req_if.sv =====
// Request channel: opcode, received byte and read index with valid/ready.
interface cfp_req_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source(output valid, output opcode, output rx_byte, output read_index, input ready);
	modport sink(input valid, input opcode, input rx_byte, input read_index, output ready);
endinterface

// ===== src/cfp_rsp_if.sv =====
// Result channel: event, latest header fields, read data and counters with valid/ready.
interface cfp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  frame_kind;
	logic [7:0]  sequence_number;
	logic [8:0]  body_length;
	logic [7:0]  read_data;
	logic [31:0] valid_frame_count;
	logic [31:0] crc_error_count;
	logic [31:0] format_error_count;

	modport source(output valid, output event_res, output frame_kind,
		output sequence_number, output body_length, output read_data,
		output valid_frame_count, output crc_error_count, output format_error_count,
		input ready);
	modport sink(input valid, input event_res, input frame_kind,
		input sequence_number, input body_length, input read_data,
		input valid_frame_count, input crc_error_count, input format_error_count,
		output ready);
endinterface

// ===== src/cfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/cfp_parser.sv =====
// Frame parse state machine, running CRC, counters and payload buffer.
module cfp_parser #(
	parameter int MAX_PAYLOAD = cfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic           opcode,
	input  logic [7:0]     rx_byte,
	input  logic [7:0]     read_index,
	input  logic [7:0]     version,
	output cfp_pkg::event_t ev,
	output cfp_pkg::stat_t  stat,
	output logic [7:0]     read_data
);
	localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int AW    = MAX_PAYLOAD > 1 ? $clog2(MAX_PAYLOAD) : 1;

	cfp_pkg::phase_t  phase_q, phase_d;
	logic [2:0]       hdr_pos_q;
	logic [7:0]       hdr_q [4];
	logic [LEN_W-1:0] pay_pos_q;
	logic [LEN_W-1:0] pay_pos_inc;
	logic [15:0]      crc_q;
	logic [15:0]      crc_next;
	logic [7:0]       chk_lo_q;
	logic [7:0]       ftype_q;
	logic [7:0]       fseq_q;
	logic [LEN_W-1:0] flen_q;
	logic [31:0]      good_q;
	logic [31:0]      bad_crc_q;
	logic [31:0]      bad_fmt_q;
	logic             rd_sel_s1;

	logic             feed;
	logic             rd_req;
	logic             hdr_last;
	logic             hdr_bad;
	logic [15:0]      len16;
	logic             check_ok;
	logic             ram_we;
	logic [7:0]       ram_rdata;

	assign feed        = accept && (opcode == cfp_pkg::OP_FEED);
	assign rd_req      = accept && (opcode == cfp_pkg::OP_READ);
	assign crc_next    = cfp_pkg::crc_byte(crc_q, rx_byte);
	assign len16       = {rx_byte, hdr_q[3]};
	assign hdr_last    = (hdr_pos_q == cfp_pkg::HEADER_LEN - 3'd1);
	assign hdr_bad     = (hdr_q[0] != version) || (len16 > 16'(MAX_PAYLOAD));
	assign pay_pos_inc = pay_pos_q + LEN_W'(1);
	assign check_ok    = ({rx_byte, chk_lo_q} == crc_q);

	always_comb begin
		case (phase_q)
			cfp_pkg::PH_HUNT2: begin
				if (rx_byte == cfp_pkg::SOF_SECOND) begin
					phase_d = cfp_pkg::PH_HEADER;
				end else if (rx_byte == cfp_pkg::SOF_FIRST) begin
					phase_d = cfp_pkg::PH_HUNT2;
				end else begin
					phase_d = cfp_pkg::PH_HUNT1;
				end
			end
			cfp_pkg::PH_HEADER: begin
				if (!hdr_last) begin
					phase_d = cfp_pkg::PH_HEADER;
				end else if (hdr_bad) begin
					phase_d = cfp_pkg::PH_HUNT1;
				end else if (len16 == 16'd0) begin
					phase_d = cfp_pkg::PH_CHECK_LO;
				end else begin
					phase_d = cfp_pkg::PH_PAYLOAD;
				end
			end
			cfp_pkg::PH_PAYLOAD: begin
				phase_d = (pay_pos_inc >= flen_q) ? cfp_pkg::PH_CHECK_LO : cfp_pkg::PH_PAYLOAD;
			end
			cfp_pkg::PH_CHECK_LO: begin
				phase_d = cfp_pkg::PH_CHECK_HI;
			end
			cfp_pkg::PH_CHECK_HI: begin
				phase_d = cfp_pkg::PH_HUNT1;
			end
			default: begin
				phase_d = (rx_byte == cfp_pkg::SOF_FIRST) ? cfp_pkg::PH_HUNT2 : cfp_pkg::PH_HUNT1;
			end
		endcase
	end

	always_comb begin
		ev     = cfp_pkg::EV_NONE;
		ram_we = 1'b0;
		if (feed) begin
			case (phase_q)
				cfp_pkg::PH_HEADER: begin
					if (hdr_last && hdr_bad) begin
						ev = cfp_pkg::EV_FORMAT;
					end
				end
				cfp_pkg::PH_PAYLOAD: begin
					ram_we = 1'b1;
				end
				cfp_pkg::PH_CHECK_HI: begin
					ev = check_ok ? cfp_pkg::EV_OK : cfp_pkg::EV_CRC;
				end
				default: begin
					ev = cfp_pkg::EV_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= cfp_pkg::PH_HUNT1;
			hdr_pos_q <= '0;
			pay_pos_q <= '0;
			crc_q     <= cfp_pkg::CRC_INIT;
			chk_lo_q  <= '0;
			ftype_q   <= '0;
			fseq_q    <= '0;
			flen_q    <= '0;
			good_q    <= '0;
			bad_crc_q <= '0;
			bad_fmt_q <= '0;
		end else if (feed) begin
			phase_q <= phase_d;
			case (phase_q)
				cfp_pkg::PH_HUNT2: begin
					if (rx_byte == cfp_pkg::SOF_SECOND) begin
						hdr_pos_q <= '0;
						crc_q     <= cfp_pkg::CRC_INIT;
					end
				end
				cfp_pkg::PH_HEADER: begin
					if (hdr_last && hdr_bad) begin
						bad_fmt_q <= bad_fmt_q + 32'd1;
						hdr_pos_q <= '0;
						pay_pos_q <= '0;
						chk_lo_q  <= '0;
						crc_q     <= cfp_pkg::CRC_INIT;
					end else begin
						hdr_pos_q <= hdr_pos_q + 3'd1;
						crc_q     <= crc_next;
						if (hdr_last) begin
							ftype_q   <= hdr_q[1];
							fseq_q    <= hdr_q[2];
							flen_q    <= LEN_W'(len16);
							pay_pos_q <= '0;
						end
					end
				end
				cfp_pkg::PH_PAYLOAD: begin
					pay_pos_q <= pay_pos_inc;
					crc_q     <= crc_next;
				end
				cfp_pkg::PH_CHECK_LO: begin
					chk_lo_q <= rx_byte;
				end
				cfp_pkg::PH_CHECK_HI: begin
					if (check_ok) begin
						good_q <= good_q + 32'd1;
					end else begin
						bad_crc_q <= bad_crc_q + 32'd1;
					end
					hdr_pos_q <= '0;
					pay_pos_q <= '0;
					chk_lo_q  <= '0;
					crc_q     <= cfp_pkg::CRC_INIT;
				end
				default: begin
					hdr_pos_q <= hdr_pos_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (feed && phase_q == cfp_pkg::PH_HEADER && hdr_pos_q < 3'd4) begin
			hdr_q[hdr_pos_q[1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_sel_s1 <= 1'b0;
		end else if (accept) begin
			rd_sel_s1 <= (opcode == cfp_pkg::OP_READ) && (32'(read_index) < 32'(MAX_PAYLOAD));
		end
	end

	cfp_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(pay_pos_q)),
		.wdata (rx_byte),
		.re    (rd_req),
		.raddr (AW'(read_index)),
		.rdata (ram_rdata)
	);

	assign read_data = rd_sel_s1 ? ram_rdata : 8'd0;

	assign stat.frame_kind         = ftype_q;
	assign stat.sequence_number    = fseq_q;
	assign stat.body_length        = 9'(flen_q);
	assign stat.valid_frame_count  = good_q;
	assign stat.crc_error_count    = bad_crc_q;
	assign stat.format_error_count = bad_fmt_q;

	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> pay_pos_q < flen_q)
		else $error("payload write beyond frame length");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(ev == cfp_pkg::EV_OK || ev == cfp_pkg::EV_CRC)
		|=> phase_q == cfp_pkg::PH_HUNT1 && crc_q == cfp_pkg::CRC_INIT)
		else $error("frame end did not restart the hunt");

	a_format_counted: assert property (@(posedge clk) disable iff (!arst_n)
		ev == cfp_pkg::EV_FORMAT |=> bad_fmt_q == $past(bad_fmt_q) + 32'd1)
		else $error("format error not counted");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == cfp_pkg::PH_HEADER |-> hdr_pos_q < cfp_pkg::HEADER_LEN)
		else $error("header position overrun");
endmodule

// ===== src/crc16_frame_parser.sv =====
// Top level: request/result handshake, version register and result stage.
// Byte-serial frame parser (A5 5A, five-byte header, payload, CRC-16 low byte first).
// One request per cycle is taken, feed or read alike, unless the result stalls; its
// result is registered on acceptance, read data coming from the registered payload
// RAM read. A new request is taken while the result register is empty or being
// drained in the same cycle. The buffer needs no clearing after reset. The user must
// write protocol_version only while the block is idle; the block does not enforce it.
module crc16_frame_parser #(
	parameter int MAX_PAYLOAD = cfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	cfp_req_if.sink    req,
	cfp_rsp_if.source  rsp
);
	logic [7:0]      version_q;
	logic            valid_s1;
	cfp_pkg::event_t event_s1;
	cfp_pkg::event_t ev;
	cfp_pkg::stat_t  stat;
	logic [7:0]      read_data;
	logic            accept;

	assign req.ready = !valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= cfp_pkg::VERSION_RST;
		end else if (cfg_we) begin
			version_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			event_s1 <= cfp_pkg::EV_NONE;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			event_s1 <= ev;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	cfp_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (req.opcode),
		.rx_byte    (req.rx_byte),
		.read_index (req.read_index),
		.version    (version_q),
		.ev         (ev),
		.stat       (stat),
		.read_data  (read_data)
	);

	assign rsp.valid              = valid_s1;
	assign rsp.event_res          = event_s1;
	assign rsp.frame_kind         = stat.frame_kind;
	assign rsp.sequence_number    = stat.sequence_number;
	assign rsp.body_length        = stat.body_length;
	assign rsp.read_data          = read_data;
	assign rsp.valid_frame_count  = stat.valid_frame_count;
	assign rsp.crc_error_count    = stat.crc_error_count;
	assign rsp.format_error_count = stat.format_error_count;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request produced no result");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !rsp.ready |-> !req.ready)
		else $error("request taken while result stalled");

	a_read_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.opcode == cfp_pkg::OP_READ |=> event_s1 == cfp_pkg::EV_NONE)
		else $error("read request raised an event");
endmodule
